// ===== src/umep_pkg.sv =====
// Package with shared types and constants of the USB-MIDI event packer.
`timescale 1ns / 1ps
package umep_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic       ACT_SHORT = 1'b0;
	localparam logic       ACT_SYSEX = 1'b1;

	localparam logic [3:0] CODE_SYSEX_START     = 4'h4;
	localparam logic [3:0] CODE_SYSEX_END_ONE   = 4'h5;
	localparam logic [3:0] CODE_SYSEX_END_TWO   = 4'h6;
	localparam logic [3:0] CODE_SYSEX_END_THREE = 4'h7;

	localparam logic [1:0] HELD_EMPTY = 2'd0;
	localparam logic [1:0] HELD_ONE   = 2'd1;
	localparam logic [1:0] HELD_TWO   = 2'd2;
	localparam logic [1:0] HELD_FULL  = 2'd3;

	typedef struct packed {
		logic [7:0] header;
		logic [7:0] data_one;
		logic [7:0] data_two;
		logic [7:0] data_three;
		logic       run_end;
	} pkt_t;

	// One queue entry: the packets caused by one item, one or two of them.
	typedef struct packed {
		pkt_t first;
		pkt_t second;
		logic two;
	} cmd_t;

	typedef struct packed {
		logic wr;
		cmd_t cmd;
	} wr_req_t;

	typedef struct packed {
		logic avail;
		cmd_t cmd;
	} rd_side_t;

endpackage

// ===== src/umep_front.sv =====
// Front part: accepts items, tracks the SysEx group and builds packet commands.
`timescale 1ns / 1ps
module umep_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             action,
	input  logic [4:0]       cable,
	input  logic [7:0]       byte_a,
	input  logic [7:0]       byte_b,
	input  logic [7:0]       byte_c,
	input  logic [1:0]       msg_len,
	input  logic             end_of_sysex,
	output umep_pkg::wr_req_t req
);
	import umep_pkg::*;

	logic [7:0] held_q [3];
	logic [7:0] held_nx [3];
	logic [1:0] held_count_q;
	logic       start_sent_q;
	logic [3:0] cn;
	logic [1:0] len_eff;
	logic       flush;
	logic [1:0] cnt_a;
	logic [1:0] cnt_b;
	logic       start_a;
	logic       send_end;
	logic [3:0] end_code;
	pkt_t       short_pkt;
	pkt_t       start_pkt;
	pkt_t       end_pkt;
	logic       sysex_acc;

	assign cn        = cable[3:0] + 4'hF;
	assign len_eff   = (msg_len == 2'd0) ? 2'd1 : msg_len;
	assign sysex_acc = accept && (action == ACT_SYSEX);

	assign flush   = (held_count_q == HELD_FULL);
	assign cnt_a   = flush ? HELD_EMPTY : held_count_q;
	assign cnt_b   = cnt_a + 2'd1;
	assign start_a = start_sent_q || flush;
	assign send_end = end_of_sysex && (start_a || (cnt_b == HELD_FULL));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			held_nx[i] = (cnt_a == 2'(i)) ? byte_a : held_q[i];
		end
	end

	always_comb begin
		case (cnt_b)
			HELD_ONE:  end_code = CODE_SYSEX_END_ONE;
			HELD_TWO:  end_code = CODE_SYSEX_END_TWO;
			HELD_FULL: end_code = CODE_SYSEX_END_THREE;
			default:   end_code = CODE_SYSEX_END_ONE;
		endcase
	end

	always_comb begin
		short_pkt.header     = {cn, byte_a[7:4]};
		short_pkt.data_one   = byte_a;
		short_pkt.data_two   = (len_eff >= 2'd2) ? byte_b : 8'h00;
		short_pkt.data_three = (len_eff >= 2'd3) ? byte_c : 8'h00;
		short_pkt.run_end    = 1'b1;

		start_pkt.header     = {cn, CODE_SYSEX_START};
		start_pkt.data_one   = held_q[0];
		start_pkt.data_two   = held_q[1];
		start_pkt.data_three = held_q[2];
		start_pkt.run_end    = !end_of_sysex;

		end_pkt.header       = {cn, end_code};
		end_pkt.data_one     = held_nx[0];
		end_pkt.data_two     = (cnt_b >= HELD_TWO) ? held_nx[1] : 8'h00;
		end_pkt.data_three   = (cnt_b >= HELD_FULL) ? held_nx[2] : 8'h00;
		end_pkt.run_end      = 1'b1;
	end

	always_comb begin
		req.wr         = 1'b0;
		req.cmd.first  = short_pkt;
		req.cmd.second = end_pkt;
		req.cmd.two    = 1'b0;
		if (accept) begin
			if (action == ACT_SHORT) begin
				req.wr = 1'b1;
			end else if (flush) begin
				req.wr        = 1'b1;
				req.cmd.first = start_pkt;
				req.cmd.two   = send_end;
			end else if (send_end) begin
				req.wr        = 1'b1;
				req.cmd.first = end_pkt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= HELD_EMPTY;
			start_sent_q <= 1'b0;
		end else if (sysex_acc) begin
			if (end_of_sysex) begin
				held_count_q <= HELD_EMPTY;
				start_sent_q <= 1'b0;
			end else begin
				held_count_q <= cnt_b;
				start_sent_q <= start_a;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sysex_acc) begin
			held_q <= held_nx;
		end
	end

	// A group went out, so at least the byte after it is held.
	a_start_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		start_sent_q |-> (held_count_q != HELD_EMPTY))
		else $error("start flag set with no held bytes");

	a_short_keeps_sysex: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action == ACT_SHORT)) |=>
			(held_count_q == $past(held_count_q)) && (start_sent_q == $past(start_sent_q)))
		else $error("short message disturbed SysEx state");

endmodule

// ===== src/umep_queue.sv =====
// Command queue between the front and back parts.
`timescale 1ns / 1ps
module umep_queue #(
	parameter int Depth = umep_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  umep_pkg::wr_req_t  req,
	output logic               full,
	input  logic               rd,
	output umep_pkg::rd_side_t head
);
	import umep_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	cmd_t          mem [Depth];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full       = (cnt_q == CW'(Depth));
	assign head.avail = (cnt_q != '0);
	assign head.cmd   = mem[rd_ptr_q];
	assign do_wr      = req.wr && !full;
	assign do_rd      = rd && head.avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= req.cmd;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(Depth))
		else $error("queue count above depth");

endmodule

// ===== src/umep_back.sv =====
// Back part: takes commands from the queue and sends their packets one per cycle while pop is high.
`timescale 1ns / 1ps
module umep_back (
	input  logic               clk,
	input  logic               arst_n,
	input  umep_pkg::rd_side_t head,
	output logic               rd,
	output logic               empty,
	input  logic               pop,
	output umep_pkg::pkt_t     pkt
);
	import umep_pkg::*;

	cmd_t cmd_q;
	logic cmd_valid_q;
	logic phase_q;
	logic take;
	logic advance;
	logic load;

	assign empty   = !cmd_valid_q;
	assign take    = pop && cmd_valid_q;
	assign advance = take && cmd_q.two && !phase_q;
	assign load    = !cmd_valid_q || (take && !advance);
	assign rd      = load && head.avail;
	assign pkt     = phase_q ? cmd_q.second : cmd_q.first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			cmd_valid_q <= head.avail;
			phase_q     <= 1'b0;
		end else if (advance) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= head.cmd;
		end
	end

	a_phase_only_on_pair: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (cmd_valid_q && cmd_q.two))
		else $error("second packet shown without a packet pair");

endmodule

// ===== src/usb_midi_event_packer.sv =====
// Top level of the USB-MIDI event packer.
//
//  channel  | handshake          | fields
//  ---------+--------------------+------------------------------------------------
//  input    | push / full        | action cable byte_a byte_b byte_c msg_len end_of_sysex
//  result   | pop / empty        | header data_one data_two data_three run_end
//
// One item is taken per cycle while not full; the front part builds its packets in the same
// cycle. The back part sends one packet per cycle while pop is high, so a final SysEx byte
// that also flushes a full group yields two packets; the queue of QueueDepth commands
// absorbs this. Reset clears the queue pointers, the SysEx count and start flag, and
// the result valid. full is high while the queue holds QueueDepth commands; pop low holds the result.
`timescale 1ns / 1ps
module usb_midi_event_packer #(
	parameter int QueueDepth = umep_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       action,
	input  logic [4:0] cable,
	input  logic [7:0] byte_a,
	input  logic [7:0] byte_b,
	input  logic [7:0] byte_c,
	input  logic [1:0] msg_len,
	input  logic       end_of_sysex,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] header,
	output logic [7:0] data_one,
	output logic [7:0] data_two,
	output logic [7:0] data_three,
	output logic       run_end
);
	import umep_pkg::*;

	wr_req_t  req;
	rd_side_t head;
	logic     rd;
	logic     accept;
	pkt_t     pkt;

	assign accept = push && !full;

	umep_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.action       (action),
		.cable        (cable),
		.byte_a       (byte_a),
		.byte_b       (byte_b),
		.byte_c       (byte_c),
		.msg_len      (msg_len),
		.end_of_sysex (end_of_sysex),
		.req          (req)
	);

	umep_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.full   (full),
		.rd     (rd),
		.head   (head)
	);

	umep_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.rd     (rd),
		.empty  (empty),
		.pop    (pop),
		.pkt    (pkt)
	);

	assign header     = pkt.header;
	assign data_one   = pkt.data_one;
	assign data_two   = pkt.data_two;
	assign data_three = pkt.data_three;
	assign run_end    = pkt.run_end;

endmodule
